// ===== hw/rtl/vpat_pkg.sv =====
// Types, constants, microprogram and arithmetic helpers of the velocity PI controller.
package vpat_pkg;

    localparam int THR_UP_Q16 = 26214;
    localparam int THR_DN_Q16 = 19661;
    localparam int THR_MAX_Q16 = 65536;

    localparam logic [1:0] OPC_NORMAL = 2'd0;
    localparam logic [1:0] OPC_HOVER  = 2'd1;
    localparam logic [1:0] OPC_HALT   = 2'd2;

    localparam logic [2:0] REG_GAIN_P_X   = 3'd0;
    localparam logic [2:0] REG_GAIN_P_Y   = 3'd1;
    localparam logic [2:0] REG_GAIN_P_Z   = 3'd2;
    localparam logic [2:0] REG_GAIN_I_X   = 3'd3;
    localparam logic [2:0] REG_GAIN_I_Y   = 3'd4;
    localparam logic [2:0] REG_GAIN_I_Z   = 3'd5;
    localparam logic [2:0] REG_HOVER      = 3'd6;
    localparam logic [2:0] REG_TILT_LIMIT = 3'd7;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [3:0] PC_DONE = 4'd13;
    localparam logic [3:0] PC_HALT = 4'd14;

    typedef enum logic [2:0] {
        OP_ERR,
        OP_MUL_DT,
        OP_INTEG,
        OP_MUL_I,
        OP_FIN,
        OP_HALT,
        OP_DONE
    } t_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_IF_HALT,
        JMP_ALWAYS
    } t_jmp;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        t_jmp       jmp;
        logic [3:0] target;
    } t_uword;

    typedef struct packed {
        logic [1:0]         opcode;
        logic               engaged;
        logic signed [31:0] cmd_vel_x;
        logic signed [31:0] cmd_vel_y;
        logic signed [31:0] cmd_vel_z;
        logic signed [31:0] est_vel_x;
        logic signed [31:0] est_vel_y;
        logic signed [31:0] est_vel_z;
        logic signed [31:0] ext_vel_x;
        logic signed [31:0] ext_vel_y;
        logic signed [31:0] yaw_target;
        logic [15:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] roll_out;
        logic signed [31:0] pitch_out;
        logic signed [31:0] yaw_out;
        logic [16:0]        thrust_out;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [23:0] value;
    } t_cfg_wr;

    function automatic t_uword f_ucode(input logic [3:0] pc);
        t_uword uw;
        uw = '{op: OP_DONE, axis: AX_X, jmp: JMP_NEXT, target: PC_DONE};
        unique case (pc)
            4'd0:  uw = '{op: OP_ERR,    axis: AX_X, jmp: JMP_IF_HALT, target: PC_HALT};
            4'd1:  uw = '{op: OP_MUL_DT, axis: AX_X, jmp: JMP_NEXT,    target: PC_DONE};
            4'd2:  uw = '{op: OP_INTEG,  axis: AX_X, jmp: JMP_NEXT,    target: PC_DONE};
            4'd3:  uw = '{op: OP_MUL_I,  axis: AX_X, jmp: JMP_NEXT,    target: PC_DONE};
            4'd4:  uw = '{op: OP_FIN,    axis: AX_X, jmp: JMP_NEXT,    target: PC_DONE};
            4'd5:  uw = '{op: OP_MUL_DT, axis: AX_Y, jmp: JMP_NEXT,    target: PC_DONE};
            4'd6:  uw = '{op: OP_INTEG,  axis: AX_Y, jmp: JMP_NEXT,    target: PC_DONE};
            4'd7:  uw = '{op: OP_MUL_I,  axis: AX_Y, jmp: JMP_NEXT,    target: PC_DONE};
            4'd8:  uw = '{op: OP_FIN,    axis: AX_Y, jmp: JMP_NEXT,    target: PC_DONE};
            4'd9:  uw = '{op: OP_MUL_DT, axis: AX_Z, jmp: JMP_NEXT,    target: PC_DONE};
            4'd10: uw = '{op: OP_INTEG,  axis: AX_Z, jmp: JMP_NEXT,    target: PC_DONE};
            4'd11: uw = '{op: OP_MUL_I,  axis: AX_Z, jmp: JMP_NEXT,    target: PC_DONE};
            4'd12: uw = '{op: OP_FIN,    axis: AX_Z, jmp: JMP_NEXT,    target: PC_DONE};
            4'd13: uw = '{op: OP_DONE,   axis: AX_X, jmp: JMP_NEXT,    target: PC_DONE};
            4'd14: uw = '{op: OP_HALT,   axis: AX_X, jmp: JMP_ALWAYS,  target: PC_DONE};
            default: uw = '{op: OP_DONE, axis: AX_X, jmp: JMP_NEXT,    target: PC_DONE};
        endcase
        return uw;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sh0007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -42'sh00080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] f_clamp_tilt(input logic signed [42:0] v,
                                                        input logic [16:0] tl);
        logic signed [42:0] lim;
        logic signed [42:0] r;
        lim = signed'({26'd0, tl});
        r = v;
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r[31:0];
    endfunction

    function automatic logic [16:0] f_thr_clamp(input logic signed [43:0] v,
                                                input logic [16:0] hover);
        logic signed [43:0] hi;
        logic signed [43:0] lo;
        logic signed [43:0] r;
        hi = signed'({27'd0, hover}) + 44'(THR_UP_Q16);
        lo = signed'({27'd0, hover}) - 44'(THR_DN_Q16);
        r = v;
        if (r > hi) begin
            r = hi;
        end
        if (r < lo) begin
            r = lo;
        end
        if (r < 44'sd0) begin
            r = 44'sd0;
        end
        if (r > 44'(THR_MAX_Q16)) begin
            r = 44'(THR_MAX_Q16);
        end
        return r[16:0];
    endfunction

endpackage

// ===== hw/rtl/vpat_chan_if.sv =====
// Valid/ready channel interface carrying one payload struct per transaction.
interface vpat_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/velocity_pi_to_attitude_thrust.sv =====
// Three-axis PI velocity controller producing roll, pitch, yaw and thrust setpoints.
// A tick is accepted on i_in when the block is idle and is processed by a
// fifteen-step microprogram around one shared 25 x 32 bit multiplier, which is
// used three times per axis. A halted or disengaged tick skips the axis steps and
// jumps from the error step to the halt step before the done step loads the result
// into the output register. The next tick is accepted in the cycle after the result
// is loaded, even while that result still waits on o_out. Configuration writes on
// i_cfg are always accepted and should only be issued while no tick is in progress.
module velocity_pi_to_attitude_thrust (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vpat_chan_if.sink   i_in,
    vpat_chan_if.source o_out,
    vpat_chan_if.sink   i_cfg
);

    logic [23:0]               r_kp [3];
    logic [23:0]               r_ki [3];
    logic [16:0]               r_hover;
    logic [16:0]               r_tilt;

    vpat_pkg::t_in_item        r_in;
    logic                      r_busy;
    logic [3:0]                r_pc;
    logic [3:0]                n_pc;

    logic signed [31:0]        r_err [3];
    logic signed [31:0]        r_integ [3];
    logic signed [56:0]        r_prod;
    logic signed [56:0]        r_acc;

    logic signed [31:0]        r_roll;
    logic signed [31:0]        r_pitch;
    logic signed [31:0]        r_yaw;
    logic [16:0]               r_thrust;

    vpat_pkg::t_out_item       r_out;
    logic                      r_out_valid;

    vpat_pkg::t_uword          w_uw;
    logic                      w_halt;
    logic                      w_slot_free;
    logic                      w_in_fire;
    logic signed [31:0]        w_cmd [3];
    logic signed [31:0]        w_meas [3];
    logic signed [24:0]        w_mul_a;
    logic signed [31:0]        w_mul_b;
    logic signed [56:0]        w_mul;
    logic signed [41:0]        w_integ_sum;
    logic signed [57:0]        w_acc_sum;
    logic signed [41:0]        w_pi;
    logic signed [43:0]        w_thr_raw;

    assign i_in.ready  = !r_busy;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_in_fire   = i_in.valid && !r_busy;
    assign w_uw        = vpat_pkg::f_ucode(r_pc);
    assign w_halt      = !r_in.engaged || (r_in.opcode == vpat_pkg::OPC_HALT);
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        w_cmd[0]  = r_in.cmd_vel_x;
        w_cmd[1]  = r_in.cmd_vel_y;
        w_cmd[2]  = r_in.cmd_vel_z;
        w_meas[0] = (r_in.opcode == vpat_pkg::OPC_HOVER) ? r_in.ext_vel_x : r_in.est_vel_x;
        w_meas[1] = (r_in.opcode == vpat_pkg::OPC_HOVER) ? r_in.ext_vel_y : r_in.est_vel_y;
        w_meas[2] = r_in.est_vel_z;
    end

    always_comb begin
        case (w_uw.op)
            vpat_pkg::OP_MUL_DT: begin
                w_mul_a = signed'({9'd0, r_in.time_step});
                w_mul_b = r_err[w_uw.axis];
            end
            vpat_pkg::OP_INTEG: begin
                w_mul_a = signed'({1'b0, r_kp[w_uw.axis]});
                w_mul_b = r_err[w_uw.axis];
            end
            default: begin
                w_mul_a = signed'({1'b0, r_ki[w_uw.axis]});
                w_mul_b = r_integ[w_uw.axis];
            end
        endcase
    end

    assign w_mul       = w_mul_a * w_mul_b;
    assign w_integ_sum = 42'(r_integ[w_uw.axis]) + 42'(signed'(r_prod[56:16]));
    assign w_acc_sum   = 58'(r_acc) + 58'(r_prod);
    assign w_pi        = w_acc_sum[57:16];
    assign w_thr_raw   = signed'({27'd0, r_hover}) - 44'(w_pi);

    always_comb begin
        n_pc = r_pc + 4'd1;
        unique case (w_uw.jmp)
            vpat_pkg::JMP_IF_HALT: begin
                if (w_halt) begin
                    n_pc = w_uw.target;
                end
            end
            vpat_pkg::JMP_ALWAYS: begin
                n_pc = w_uw.target;
            end
            default: begin
                n_pc = r_pc + 4'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_fire) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
            end else if (r_busy) begin
                if (w_uw.op == vpat_pkg::OP_DONE) begin
                    if (w_slot_free) begin
                        r_busy      <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end else begin
                    r_pc <= n_pc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in <= i_in.data;
        end
        if (r_busy && (w_uw.op == vpat_pkg::OP_DONE) && w_slot_free) begin
            r_out.roll_out   <= r_roll;
            r_out.pitch_out  <= r_pitch;
            r_out.yaw_out    <= r_yaw;
            r_out.thrust_out <= r_thrust;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_integ[a] <= '0;
            end
        end else if (r_busy) begin
            case (w_uw.op)
                vpat_pkg::OP_INTEG: begin
                    r_integ[w_uw.axis] <= vpat_pkg::f_sat32(w_integ_sum);
                end
                vpat_pkg::OP_HALT: begin
                    for (int a = 0; a < 3; a++) begin
                        r_integ[a] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            case (w_uw.op) inside
                vpat_pkg::OP_ERR: begin
                    for (int a = 0; a < 3; a++) begin
                        r_err[a] <= vpat_pkg::f_sat32(42'(w_cmd[a]) - 42'(w_meas[a]));
                    end
                    r_yaw <= r_in.engaged ? r_in.yaw_target : 32'sd0;
                end
                vpat_pkg::OP_MUL_DT, vpat_pkg::OP_INTEG: begin
                    r_prod <= w_mul;
                end
                vpat_pkg::OP_MUL_I: begin
                    r_acc  <= r_prod;
                    r_prod <= w_mul;
                end
                vpat_pkg::OP_FIN: begin
                    case (w_uw.axis)
                        vpat_pkg::AX_X: r_pitch  <= vpat_pkg::f_clamp_tilt(-43'(w_pi), r_tilt);
                        vpat_pkg::AX_Y: r_roll   <= vpat_pkg::f_clamp_tilt(43'(w_pi), r_tilt);
                        default:        r_thrust <= vpat_pkg::f_thr_clamp(w_thr_raw, r_hover);
                    endcase
                end
                vpat_pkg::OP_HALT: begin
                    r_roll   <= '0;
                    r_pitch  <= '0;
                    r_thrust <= vpat_pkg::f_thr_clamp(
                        signed'({27'd0, r_hover}) - 44'(vpat_pkg::THR_DN_Q16), r_hover);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_kp[a] <= '0;
                r_ki[a] <= '0;
            end
            r_hover <= '0;
            r_tilt  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                vpat_pkg::REG_GAIN_P_X:   r_kp[0] <= i_cfg.data.value;
                vpat_pkg::REG_GAIN_P_Y:   r_kp[1] <= i_cfg.data.value;
                vpat_pkg::REG_GAIN_P_Z:   r_kp[2] <= i_cfg.data.value;
                vpat_pkg::REG_GAIN_I_X:   r_ki[0] <= i_cfg.data.value;
                vpat_pkg::REG_GAIN_I_Y:   r_ki[1] <= i_cfg.data.value;
                vpat_pkg::REG_GAIN_I_Z:   r_ki[2] <= i_cfg.data.value;
                vpat_pkg::REG_HOVER:      r_hover <= i_cfg.data.value[16:0];
                vpat_pkg::REG_TILT_LIMIT: r_tilt  <= i_cfg.data.value[16:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/vpat_checker.sv =====
// Port-level assertions for the velocity PI controller, bound to its top level.
module vpat_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input vpat_pkg::t_out_item i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed or dropped before its transaction completed");

    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("new tick accepted while the previous one is in progress");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

    a_thrust_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.thrust_out <= 17'd65536))
        else $error("thrust above full scale");

    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a tick in progress");

endmodule

bind velocity_pi_to_attitude_thrust vpat_checker u_vpat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== tb/tb_velocity_pi_to_attitude_thrust.sv =====
// Self-checking testbench for the three-axis PI velocity controller.
module tb_velocity_pi_to_attitude_thrust;

    localparam logic [1:0]         OPC_UNUSED    = 2'd3;
    localparam logic signed [31:0] VEL_MAX       = 32'sh7FFFFFFF;
    localparam logic signed [31:0] VEL_MIN       = 32'sh80000000;
    localparam logic signed [31:0] ONE_Q16       = 32'sd65536;
    localparam int                 STALL_LIMIT   = 3000;
    localparam int                 SETTLE_CYCLES = 24;
    localparam int                 LONG_HOLD     = 250;
    localparam int                 PRINT_CAP     = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    vpat_chan_if #(.T(vpat_pkg::t_in_item))  in_ch ();
    vpat_chan_if #(.T(vpat_pkg::t_out_item)) out_ch ();
    vpat_chan_if #(.T(vpat_pkg::t_cfg_wr))   cfg_ch ();

    velocity_pi_to_attitude_thrust dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    logic [23:0] kp_x = '0, kp_y = '0, kp_z = '0;
    logic [23:0] ki_x = '0, ki_y = '0, ki_z = '0;
    logic [16:0] hover_q16 = '0;
    logic [16:0] tilt_q16  = '0;
    longint      integ_x = 0, integ_y = 0, integ_z = 0;

    vpat_pkg::t_in_item  pending_ticks[$];
    vpat_pkg::t_out_item expected_setpoints[$];
    int        ticks_issued     = 0;
    int        results_done     = 0;
    int        mismatches       = 0;
    int        settings_loaded  = 0;
    int        long_stalls      = 0;
    int        rx_hold_left     = 0;
    bit        tick_taken       = 1'b0;
    bit        no_gaps          = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint sat_q31(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint clamp_span(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic longint pi_sum(input logic [23:0] kp, input logic [23:0] ki,
                                      input longint err, input longint integ);
        longint p;
        longint i;
        p = longint'({40'd0, kp});
        i = longint'({40'd0, ki});
        return (p * err + i * integ) >>> 16;
    endfunction

    function automatic vpat_pkg::t_out_item predict_setpoints(input vpat_pkg::t_in_item t);
        vpat_pkg::t_out_item r;
        longint    hov, hi, lo, thr, tl, dt;
        longint    mx, my, mz, ex, ey, ez;
        r   = '0;
        hov = longint'({47'd0, hover_q16});
        hi  = hov + vpat_pkg::THR_UP_Q16;
        lo  = hov - vpat_pkg::THR_DN_Q16;
        thr = lo;
        if (!t.engaged || t.opcode == vpat_pkg::OPC_HALT) begin
            integ_x = 0;
            integ_y = 0;
            integ_z = 0;
            if (t.engaged) begin
                r.yaw_out = t.yaw_target;
            end
        end else begin
            dt = longint'({48'd0, t.time_step});
            tl = longint'({47'd0, tilt_q16});
            mx = (t.opcode == vpat_pkg::OPC_HOVER) ? $signed(t.ext_vel_x)
                                                   : $signed(t.est_vel_x);
            my = (t.opcode == vpat_pkg::OPC_HOVER) ? $signed(t.ext_vel_y)
                                                   : $signed(t.est_vel_y);
            mz = $signed(t.est_vel_z);
            ex = sat_q31(longint'($signed(t.cmd_vel_x)) - mx);
            ey = sat_q31(longint'($signed(t.cmd_vel_y)) - my);
            ez = sat_q31(longint'($signed(t.cmd_vel_z)) - mz);
            integ_x = sat_q31(integ_x + ((dt * ex) >>> 16));
            integ_y = sat_q31(integ_y + ((dt * ey) >>> 16));
            integ_z = sat_q31(integ_z + ((dt * ez) >>> 16));
            r.pitch_out = 32'(clamp_span(-pi_sum(kp_x, ki_x, ex, integ_x), -tl, tl));
            r.roll_out  = 32'(clamp_span(pi_sum(kp_y, ki_y, ey, integ_y), -tl, tl));
            r.yaw_out   = t.yaw_target;
            thr = clamp_span(hov - pi_sum(kp_z, ki_z, ez, integ_z), lo, hi);
        end
        r.thrust_out = 17'(clamp_span(thr, 0, vpat_pkg::THR_MAX_Q16));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin : sample_channels
        vpat_pkg::t_out_item want;
        vpat_pkg::t_out_item got;
        if (!i_rst_n) begin
            integ_x = 0;
            integ_y = 0;
            integ_z = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.data.index)
                    vpat_pkg::REG_GAIN_P_X:   kp_x = cfg_ch.data.value;
                    vpat_pkg::REG_GAIN_P_Y:   kp_y = cfg_ch.data.value;
                    vpat_pkg::REG_GAIN_P_Z:   kp_z = cfg_ch.data.value;
                    vpat_pkg::REG_GAIN_I_X:   ki_x = cfg_ch.data.value;
                    vpat_pkg::REG_GAIN_I_Y:   ki_y = cfg_ch.data.value;
                    vpat_pkg::REG_GAIN_I_Z:   ki_z = cfg_ch.data.value;
                    vpat_pkg::REG_HOVER:      hover_q16 = cfg_ch.data.value[16:0];
                    vpat_pkg::REG_TILT_LIMIT: tilt_q16 = cfg_ch.data.value[16:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_setpoints.push_back(predict_setpoints(in_ch.data));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_setpoints.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no tick outstanding: %h",
                                              results_done, got));
                end else begin
                    want = expected_setpoints.pop_front();
                    if (got.roll_out !== want.roll_out) begin
                        report_mismatch($sformatf("result %0d roll_out %h, expected %h",
                                                  results_done, got.roll_out, want.roll_out));
                    end
                    if (got.pitch_out !== want.pitch_out) begin
                        report_mismatch($sformatf("result %0d pitch_out %h, expected %h",
                                                  results_done, got.pitch_out, want.pitch_out));
                    end
                    if (got.yaw_out !== want.yaw_out) begin
                        report_mismatch($sformatf("result %0d yaw_out %h, expected %h",
                                                  results_done, got.yaw_out, want.yaw_out));
                    end
                    if (got.thrust_out !== want.thrust_out) begin
                        report_mismatch($sformatf("result %0d thrust_out %h, expected %h",
                                                  results_done, got.thrust_out,
                                                  want.thrust_out));
                    end
                end
                results_done++;
            end
        end
        tick_taken = in_ch.valid && in_ch.ready;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || tick_taken) begin
            if (pending_ticks.size() != 0 && (no_gaps || $urandom_range(99) >= 8)) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_ticks.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // The output side twice holds off for a long stretch while plenty of ticks are
    // still queued, so that the block fills up and stops taking input.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (rx_hold_left == 0 && long_stalls < 2 && pending_ticks.size() > 40 &&
                results_done >= 150 + 300 * long_stalls) begin
                rx_hold_left = LONG_HOLD;
                long_stalls++;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_gaps || $urandom_range(99) >= 8;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("No transaction for %0d cycles, run abandoned.", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic write_register(input logic [2:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= vpat_pkg::t_cfg_wr'{index: idx, value: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic load_settings(input logic [23:0] pkx, input logic [23:0] pky,
                                 input logic [23:0] pkz, input logic [23:0] ikx,
                                 input logic [23:0] iky, input logic [23:0] ikz,
                                 input logic [16:0] hov, input logic [16:0] tl);
        write_register(vpat_pkg::REG_GAIN_P_X, pkx);
        write_register(vpat_pkg::REG_GAIN_P_Y, pky);
        write_register(vpat_pkg::REG_GAIN_P_Z, pkz);
        write_register(vpat_pkg::REG_GAIN_I_X, ikx);
        write_register(vpat_pkg::REG_GAIN_I_Y, iky);
        write_register(vpat_pkg::REG_GAIN_I_Z, ikz);
        write_register(vpat_pkg::REG_HOVER, 24'(hov));
        write_register(vpat_pkg::REG_TILT_LIMIT, 24'(tl));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic wait_settled();
        while (results_done < ticks_issued) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_tick(input vpat_pkg::t_in_item t);
        pending_ticks.push_back(t);
        ticks_issued++;
    endtask

    function automatic vpat_pkg::t_in_item directed_tick(input logic [1:0] opc,
                                                         input logic eng,
                                                         input logic signed [31:0] cmd,
                                                         input logic signed [31:0] est,
                                                         input logic signed [31:0] ext,
                                                         input logic signed [31:0] yaw,
                                                         input logic [15:0] dt);
        vpat_pkg::t_in_item t;
        t.opcode     = opc;
        t.engaged    = eng;
        t.cmd_vel_x  = cmd;
        t.cmd_vel_y  = cmd;
        t.cmd_vel_z  = cmd;
        t.est_vel_x  = est;
        t.est_vel_y  = est;
        t.est_vel_z  = est;
        t.ext_vel_x  = ext;
        t.ext_vel_y  = ext;
        t.yaw_target = yaw;
        t.time_step  = dt;
        return t;
    endfunction

    function automatic logic signed [31:0] random_speed();
        case ($urandom_range(9)) inside
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(3))
                    0: return VEL_MAX;
                    1: return VEL_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return int'($urandom_range(1048576)) - 524288;
        endcase
    endfunction

    function automatic logic signed [31:0] nearby_speed(input logic signed [31:0] base);
        if ($urandom_range(3) == 0) begin
            return random_speed();
        end
        return base + (int'($urandom_range(131072)) - 65536);
    endfunction

    function automatic logic [15:0] random_interval();
        int k;
        k = $urandom_range(19);
        if (k < 14) begin
            return 16'($urandom_range(1311, 1));
        end
        if (k < 17) begin
            return 16'($urandom_range(65535));
        end
        return (k == 17) ? 16'd0 : 16'hFFFF;
    endfunction

    function automatic vpat_pkg::t_in_item random_tick();
        vpat_pkg::t_in_item t;
        int       pick;
        pick = $urandom_range(99);
        t.opcode = (pick < 45) ? vpat_pkg::OPC_NORMAL : (pick < 78) ? vpat_pkg::OPC_HOVER :
                   (pick < 90) ? vpat_pkg::OPC_HALT : OPC_UNUSED;
        t.engaged    = $urandom_range(99) < 90;
        t.est_vel_x  = random_speed();
        t.est_vel_y  = random_speed();
        t.est_vel_z  = random_speed();
        t.ext_vel_x  = nearby_speed(t.est_vel_x);
        t.ext_vel_y  = nearby_speed(t.est_vel_y);
        t.cmd_vel_x  = nearby_speed((t.opcode == vpat_pkg::OPC_HOVER) ? t.ext_vel_x
                                                                      : t.est_vel_x);
        t.cmd_vel_y  = nearby_speed((t.opcode == vpat_pkg::OPC_HOVER) ? t.ext_vel_y
                                                                      : t.est_vel_y);
        t.cmd_vel_z  = nearby_speed(t.est_vel_z);
        t.yaw_target = random_speed();
        t.time_step  = random_interval();
        return t;
    endfunction

    function automatic logic [23:0] random_gain();
        case ($urandom_range(7))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(16777215));
            default: return 24'($urandom_range(262144));
        endcase
    endfunction

    function automatic logic [16:0] random_level(input int top);
        case ($urandom_range(4))
            0: return 17'd0;
            1: return 17'(top);
            default: return 17'($urandom_range(top));
        endcase
    endfunction

    initial begin : stimulus
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Settings straight out of reset: zero gains and zero hover thrust.
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b0, ONE_Q16, 0, 0, ONE_Q16,
                                 16'd1000));
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, ONE_Q16, -ONE_Q16, 0, VEL_MAX,
                                 16'd1000));
        wait_settled();

        load_settings(24'd65536, 24'd65536, 24'd65536, 24'd32768, 24'd32768, 24'd32768,
                      17'd32768, 17'd34304);
        queue_tick(directed_tick(vpat_pkg::OPC_HALT, 1'b0, VEL_MAX, VEL_MIN, 0, VEL_MAX,
                                 16'hFFFF));
        queue_tick(directed_tick(vpat_pkg::OPC_HALT, 1'b1, ONE_Q16, 0, 0, VEL_MIN, 16'd1000));
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, VEL_MAX, VEL_MIN, 0, ONE_Q16,
                                 16'hFFFF));
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, VEL_MAX, VEL_MIN, 0, ONE_Q16,
                                 16'hFFFF));
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, VEL_MIN, VEL_MAX, 0, -ONE_Q16,
                                 16'hFFFF));
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, VEL_MIN, VEL_MAX, 0, -ONE_Q16,
                                 16'hFFFF));
        queue_tick(directed_tick(vpat_pkg::OPC_HOVER, 1'b1, 0, -3 * ONE_Q16, ONE_Q16, 0,
                                 16'd1311));
        queue_tick(directed_tick(vpat_pkg::OPC_HOVER, 1'b1, 0, 0, VEL_MIN, VEL_MAX, 16'hFFFF));
        queue_tick(directed_tick(OPC_UNUSED, 1'b1, 2 * ONE_Q16, ONE_Q16, VEL_MAX, 0, 16'd655));
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, ONE_Q16, -ONE_Q16, 0, 0, 16'd0));
        queue_tick(directed_tick(vpat_pkg::OPC_HOVER, 1'b0, ONE_Q16, 0, 0, ONE_Q16, 16'd100));
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, 0, 0, 0, 0, 16'd0));
        wait_settled();

        load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                      17'd65536, 17'd102944);
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, VEL_MAX, VEL_MIN, 0, VEL_MAX,
                                 16'hFFFF));
        queue_tick(directed_tick(vpat_pkg::OPC_NORMAL, 1'b1, VEL_MIN, VEL_MAX, 0, VEL_MIN,
                                 16'hFFFF));
        queue_tick(directed_tick(vpat_pkg::OPC_HOVER, 1'b1, VEL_MAX, VEL_MAX, VEL_MIN, 0,
                                 16'd1));
        queue_tick(directed_tick(OPC_UNUSED, 1'b1, -ONE_Q16, ONE_Q16, 0, -32'sd1, 16'd655));
        queue_tick(directed_tick(vpat_pkg::OPC_HALT, 1'b1, ONE_Q16, 0, 0, 32'sd12345,
                                 16'd655));
        wait_settled();

        load_settings('0, '0, '0, '0, '0, '0, 17'd0, 17'd0);
        repeat (20) queue_tick(random_tick());
        wait_settled();

        for (int phase = 0; phase < 5; phase++) begin
            load_settings(random_gain(), random_gain(), random_gain(), random_gain(),
                          random_gain(), random_gain(), random_level(vpat_pkg::THR_MAX_Q16),
                          random_level(102944));
            no_gaps = (phase == 2);
            repeat (130) queue_tick(random_tick());
            wait_settled();
            no_gaps = 1'b0;
        end

        if (expected_setpoints.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_setpoints.size()));
        end
        $display("Covered %0d ticks under %0d controller settings, %0d results checked.",
                 ticks_issued, settings_loaded + 1, results_done);
        $display("Output side held off %0d times for long stretches; %0d mismatches.",
                 long_stalls, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
